// ===== src/usbep0_pkg.sv =====
// ----------------------------------------------------------------------------
// usbep0_pkg: shared codes for the control endpoint responder
// Event, action, phase, data source and request codes, and descriptor sizes.
// ----------------------------------------------------------------------------
package usbep0_pkg;

	// Event codes on the input channel
	localparam logic [2:0] OP_BUS_RESET     = 3'd0;
	localparam logic [2:0] OP_CONNECT_DONE  = 3'd1;
	localparam logic [2:0] OP_DISCONNECT    = 3'd2;
	localparam logic [2:0] OP_XFER_COMPLETE = 3'd3;
	localparam logic [2:0] OP_NRDY_DATA     = 3'd4;
	localparam logic [2:0] OP_NRDY_STATUS   = 3'd5;

	// Endpoint actions on the result channel
	localparam logic [2:0] ACT_NONE       = 3'd0;
	localparam logic [2:0] ACT_ARM_SETUP  = 3'd1;
	localparam logic [2:0] ACT_QUEUE_DATA = 3'd2;
	localparam logic [2:0] ACT_STATUS2    = 3'd3;
	localparam logic [2:0] ACT_STATUS3    = 3'd4;
	localparam logic [2:0] ACT_STALL      = 3'd5;

	// Data stage sources
	localparam logic [3:0] SRC_NONE      = 4'd0;
	localparam logic [3:0] SRC_QUALIFIER = 4'd3;
	localparam logic [3:0] SRC_STRING0   = 4'd4;
	localparam logic [3:0] SRC_REPLY     = 4'd8;

	// Standard request codes
	localparam logic [7:0] REQ_GET_STATUS        = 8'd0;
	localparam logic [7:0] REQ_CLEAR_FEATURE     = 8'd1;
	localparam logic [7:0] REQ_SET_FEATURE       = 8'd3;
	localparam logic [7:0] REQ_SET_ADDRESS       = 8'd5;
	localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'd6;
	localparam logic [7:0] REQ_GET_CONFIGURATION = 8'd8;
	localparam logic [7:0] REQ_SET_CONFIGURATION = 8'd9;
	localparam logic [7:0] REQ_GET_INTERFACE     = 8'd10;
	localparam logic [7:0] REQ_SET_INTERFACE     = 8'd11;

	// Descriptor types (high byte of wValue)
	localparam logic [7:0] DT_DEVICE    = 8'd1;
	localparam logic [7:0] DT_CONFIG    = 8'd2;
	localparam logic [7:0] DT_STRING    = 8'd3;
	localparam logic [7:0] DT_QUALIFIER = 8'd6;
	localparam logic [7:0] NUM_STRINGS  = 8'd4;

	// Control transfer phase
	typedef enum logic [2:0] {
		PH_SETUP  = 3'b001,
		PH_DATA   = 3'b010,
		PH_STATUS = 3'b100
	} phase_t;

	// Descriptor byte count by source code (low three bits)
	function automatic logic [5:0] desc_length(input logic [2:0] src);
		logic [5:0] len;
		case (src)
			3'd1:    len = 6'd18;
			3'd2:    len = 6'd32;
			3'd3:    len = 6'd10;
			3'd4:    len = 6'd4;
			3'd5:    len = 6'd10;
			3'd6:    len = 6'd18;
			3'd7:    len = 6'd34;
			default: len = 6'd0;
		endcase
		return len;
	endfunction

endpackage

// ===== src/usb_control_endpoint_responder.sv =====
// ----------------------------------------------------------------------------
// usb_control_endpoint_responder: endpoint zero standard request handler
// Turns decoded controller events into endpoint actions, one result each.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (event_valid/event_ready) carries one decoded controller
//   event per transfer: bus reset, connect done, disconnect, transfer
//   complete (setup fields read only in setup phase), not ready data and
//   not ready status. Output channel (result_valid/result_ready) carries
//   exactly one result per event: the endpoint action, data stage details,
//   address programming, configured state and bulk enable/disable pulses.
//   Path: an accepted event goes into the input register, then is decoded
//   into the result register, which drives the result channel. Throughput:
//   one event per clock while the result channel is not stalled; the decode
//   reads the endpoint state and writes it back with the result register, so
//   back-to-back events each see the state left by the one before.
//   A stalled receiver holds the result register; the input register keeps
//   taking one more event and then ready drops until the result is taken.
//   Reset: asynchronous, active low. Both stages empty, phase back to setup,
//   held request and data cleared, not configured.
// ----------------------------------------------------------------------------
module usb_control_endpoint_responder #(
	parameter int MAX_PACKET = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// event channel
	input  logic        event_valid,
	output logic        event_ready,
	input  logic [2:0]  operation,
	input  logic        direction_in,
	input  logic [7:0]  setup_request_type,
	input  logic [7:0]  setup_request,
	input  logic [15:0] setup_value,
	input  logic [15:0] setup_length,
	// result channel
	output logic        result_valid,
	input  logic        result_ready,
	output logic [2:0]  action,
	output logic        queue_endpoint,
	output logic [6:0]  transfer_length,
	output logic [3:0]  data_source,
	output logic [15:0] reply_data,
	output logic        address_write,
	output logic [6:0]  device_address,
	output logic        is_configured,
	output logic        bulk_enable_request,
	output logic        bulk_disable_request
);
	import usbep0_pkg::*;

	// Packets needed for the longest held length (six bits)
	localparam int MaxPkts = (63 + MAX_PACKET - 1) / MAX_PACKET;

	// ---------------- input register ----------------
	logic        valid_s1;
	logic [2:0]  op_s1;
	logic        dir_s1;
	logic [7:0]  rtype_s1;
	logic [7:0]  req_s1;
	logic [15:0] value_s1;
	logic [15:0] wlen_s1;

	// ---------------- result register ----------------
	logic        valid_s2;
	logic [2:0]  action_s2;
	logic        qep_s2;
	logic [6:0]  tlen_s2;
	logic [3:0]  src_s2;
	logic [15:0] reply_s2;
	logic        addr_wr_s2;
	logic [6:0]  addr_s2;
	logic        cfg_s2;
	logic        bulk_en_s2;
	logic        bulk_dis_s2;

	// ---------------- endpoint state ----------------
	phase_t      phase_q;
	logic [15:0] hreq_len_q;
	logic [3:0]  hsrc_q;
	logic [5:0]  hlen_q;
	logic [15:0] hreply_q;
	logic        cfg_q;

	// stage 1 moves forward whenever the result register is free or drains
	logic adv;
	assign adv         = !valid_s2 || result_ready;
	assign event_ready = !valid_s1 || adv;

	// ---------------- decode ----------------
	phase_t      nxt_phase;
	logic [15:0] nxt_hreq_len;
	logic [3:0]  nxt_hsrc;
	logic [5:0]  nxt_hlen;
	logic [15:0] nxt_hreply;
	logic        nxt_cfg;
	logic [2:0]  d_action;
	logic        d_qep;
	logic [6:0]  d_tlen;
	logic [3:0]  d_src;
	logic [15:0] d_reply;
	logic        d_addr_wr;
	logic [6:0]  d_addr;
	logic        d_bulk_en;
	logic        d_bulk_dis;

	logic        setup_ok;
	logic [3:0]  ld_src;
	logic [5:0]  ld_len;
	logic [15:0] ld_reply;
	logic        ld_hold;
	logic [6:0]  out_round;

	// OUT data stages round up to whole packets; at most MaxPkts packets
	always_comb begin
		out_round = {1'b0, hlen_q};
		for (int k = MaxPkts; k >= 1; k--) begin
			if (int'(hlen_q) <= k * MAX_PACKET && hlen_q != 6'd0) begin
				out_round = 7'(k * MAX_PACKET);
			end
		end
	end

	// Standard request decode of the setup fields
	always_comb begin
		setup_ok  = 1'b0;
		ld_hold   = 1'b0;
		ld_src    = SRC_NONE;
		ld_len    = 6'd0;
		ld_reply  = 16'd0;
		d_addr_wr = 1'b0;
		d_addr    = 7'd0;
		d_bulk_en = 1'b0;
		nxt_cfg   = cfg_q;
		if (rtype_s1[6:5] == 2'b00) begin
			case (req_s1)
				REQ_GET_STATUS: begin
					setup_ok = 1'b1;
					ld_hold  = 1'b1;
					ld_src   = SRC_REPLY;
					ld_len   = 6'd2;
					ld_reply = 16'h0001;
				end
				REQ_CLEAR_FEATURE, REQ_SET_FEATURE, REQ_SET_INTERFACE: begin
					setup_ok = 1'b1;
				end
				REQ_SET_ADDRESS: begin
					setup_ok  = 1'b1;
					d_addr_wr = 1'b1;
					d_addr    = value_s1[6:0];
				end
				REQ_GET_DESCRIPTOR: begin
					if (value_s1[15:8] == DT_DEVICE || value_s1[15:8] == DT_CONFIG) begin
						setup_ok = 1'b1;
						ld_src   = value_s1[11:8];
					end else if (value_s1[15:8] == DT_QUALIFIER) begin
						setup_ok = 1'b1;
						ld_src   = SRC_QUALIFIER;
					end else if (value_s1[15:8] == DT_STRING && value_s1[7:0] < NUM_STRINGS) begin
						setup_ok = 1'b1;
						ld_src   = SRC_STRING0 + {2'b00, value_s1[1:0]};
					end
					ld_hold = setup_ok;
					ld_len  = desc_length(ld_src[2:0]);
				end
				REQ_GET_CONFIGURATION: begin
					setup_ok = 1'b1;
					ld_hold  = 1'b1;
					ld_src   = SRC_REPLY;
					ld_len   = 6'd1;
					ld_reply = {15'd0, cfg_q};
				end
				REQ_SET_CONFIGURATION: begin
					if (value_s1[7:0] == 8'd1) begin
						setup_ok  = 1'b1;
						nxt_cfg   = 1'b1;
						d_bulk_en = 1'b1;
					end else if (value_s1[7:0] == 8'd0) begin
						setup_ok = 1'b1;
						nxt_cfg  = 1'b0;
					end
				end
				REQ_GET_INTERFACE: begin
					setup_ok = 1'b1;
					ld_hold  = 1'b1;
					ld_src   = SRC_REPLY;
					ld_len   = 6'd1;
				end
				default: setup_ok = 1'b0;
			endcase
		end
	end

	// Event dispatch: result fields and next endpoint state
	always_comb begin
		nxt_phase    = phase_q;
		nxt_hreq_len = hreq_len_q;
		nxt_hsrc     = hsrc_q;
		nxt_hlen     = hlen_q;
		nxt_hreply   = hreply_q;
		d_action     = ACT_NONE;
		d_qep        = 1'b0;
		d_tlen       = 7'd0;
		d_src        = SRC_NONE;
		d_reply      = 16'd0;
		d_bulk_dis   = 1'b0;
		case (op_s1)
			OP_BUS_RESET: begin
				nxt_phase  = PH_SETUP;
				d_action   = ACT_ARM_SETUP;
				d_bulk_dis = 1'b1;
			end
			OP_CONNECT_DONE: begin
				nxt_phase = PH_SETUP;
				d_action  = ACT_ARM_SETUP;
			end
			OP_XFER_COMPLETE: begin
				if (phase_q == PH_SETUP) begin
					nxt_hreq_len = wlen_s1;
					nxt_hsrc     = ld_hold ? ld_src : SRC_NONE;
					nxt_hreply   = ld_hold ? ld_reply : 16'd0;
					// every data stage clipped to wLength
					if (!ld_hold) begin
						nxt_hlen = 6'd0;
					end else if (wlen_s1 < {10'd0, ld_len}) begin
						nxt_hlen = wlen_s1[5:0];
					end else begin
						nxt_hlen = ld_len;
					end
					if (!setup_ok) begin
						d_action  = ACT_STALL;
						nxt_phase = PH_SETUP;
					end
				end else if (phase_q == PH_STATUS) begin
					d_action  = ACT_ARM_SETUP;
					nxt_phase = PH_SETUP;
				end
			end
			OP_NRDY_DATA: begin
				if (hsrc_q == SRC_NONE || hlen_q == 6'd0) begin
					d_action  = ACT_STALL;
					nxt_phase = PH_SETUP;
				end else begin
					d_action  = ACT_QUEUE_DATA;
					d_qep     = dir_s1;
					d_tlen    = dir_s1 ? {1'b0, hlen_q} : out_round;
					d_src     = hsrc_q;
					d_reply   = (hsrc_q == SRC_REPLY) ? hreply_q : 16'd0;
					nxt_phase = PH_DATA;
				end
			end
			OP_NRDY_STATUS: begin
				d_action  = (hreq_len_q != 16'd0) ? ACT_STATUS3 : ACT_STATUS2;
				d_qep     = dir_s1;
				nxt_phase = PH_STATUS;
			end
			default: d_action = ACT_NONE;
		endcase
	end

	// Setup side effects gated here so the decode stays flat, plus bus reset and disconnect
	logic       setup_evt;
	logic       f_cfg;
	logic       f_addr_wr;
	logic [6:0] f_addr;
	assign setup_evt = (op_s1 == OP_XFER_COMPLETE) && (phase_q == PH_SETUP);

	always_comb begin
		f_cfg     = cfg_q;
		f_addr_wr = 1'b0;
		f_addr    = 7'd0;
		if (op_s1 == OP_BUS_RESET || op_s1 == OP_DISCONNECT) begin
			f_cfg = 1'b0;
		end
		if (op_s1 == OP_BUS_RESET) begin
			f_addr_wr = 1'b1;
		end
		if (setup_evt) begin
			f_cfg     = nxt_cfg;
			f_addr_wr = d_addr_wr;
			f_addr    = d_addr;
		end
	end

	// ---------------- registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (event_ready) begin
			valid_s1 <= event_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (event_ready && event_valid) begin
			op_s1    <= operation;
			dir_s1   <= direction_in;
			rtype_s1 <= setup_request_type;
			req_s1   <= setup_request;
			value_s1 <= setup_value;
			wlen_s1  <= setup_length;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2   <= 1'b0;
			phase_q    <= PH_SETUP;
			hreq_len_q <= 16'd0;
			hsrc_q     <= SRC_NONE;
			hlen_q     <= 6'd0;
			hreply_q   <= 16'd0;
			cfg_q      <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				phase_q    <= nxt_phase;
				hreq_len_q <= nxt_hreq_len;
				hsrc_q     <= nxt_hsrc;
				hlen_q     <= nxt_hlen;
				hreply_q   <= nxt_hreply;
				cfg_q      <= f_cfg;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			action_s2   <= d_action;
			qep_s2      <= d_qep;
			tlen_s2     <= d_tlen;
			src_s2      <= d_src;
			reply_s2    <= d_reply;
			addr_wr_s2  <= f_addr_wr;
			addr_s2     <= f_addr;
			cfg_s2      <= f_cfg;
			bulk_en_s2  <= setup_evt && d_bulk_en;
			bulk_dis_s2 <= d_bulk_dis;
		end
	end

	assign result_valid         = valid_s2;
	assign action               = action_s2;
	assign queue_endpoint       = qep_s2;
	assign transfer_length      = tlen_s2;
	assign data_source          = src_s2;
	assign reply_data           = reply_s2;
	assign address_write        = addr_wr_s2;
	assign device_address       = addr_s2;
	assign is_configured        = cfg_s2;
	assign bulk_enable_request  = bulk_en_s2;
	assign bulk_disable_request = bulk_dis_s2;

endmodule

// ===== src/usbep0_checker.sv =====
// ----------------------------------------------------------------------------
// usbep0_checker: port-level checks for the control endpoint responder
// Result channel protocol and consistency of the result fields.
// ----------------------------------------------------------------------------
module usbep0_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        result_valid,
	input logic        result_ready,
	input logic [2:0]  action,
	input logic [6:0]  transfer_length,
	input logic [3:0]  data_source,
	input logic        address_write,
	input logic [6:0]  device_address,
	input logic        is_configured,
	input logic        bulk_enable_request,
	input logic        bulk_disable_request
);
	import usbep0_pkg::*;

	// stalled result stays valid with action, length and source unchanged
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(action)
			&& $stable(transfer_length) && $stable(data_source))
		else $error("result changed while stalled");

	// no address unless it is being programmed
	a_addr: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !address_write |-> device_address == 7'd0)
		else $error("device address without write");

	// data fields only on a queued data stage
	a_data: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && action != ACT_QUEUE_DATA
			|-> transfer_length == 7'd0 && data_source == SRC_NONE)
		else $error("data fields outside data stage");

	// bus reset drops configuration and programs address zero
	a_reset: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && bulk_disable_request
			|-> !is_configured && address_write && device_address == 7'd0
			&& action == ACT_ARM_SETUP)
		else $error("bus reset result inconsistent");

	// enabling bulk endpoints leaves the device configured
	a_enable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && bulk_enable_request |-> is_configured && !bulk_disable_request)
		else $error("bulk enable without configuration");

endmodule

bind usb_control_endpoint_responder usbep0_checker u_usbep0_checker (
	.clk                  (clk),
	.arst_n               (arst_n),
	.result_valid         (result_valid),
	.result_ready         (result_ready),
	.action               (action),
	.transfer_length      (transfer_length),
	.data_source          (data_source),
	.address_write        (address_write),
	.device_address       (device_address),
	.is_configured        (is_configured),
	.bulk_enable_request  (bulk_enable_request),
	.bulk_disable_request (bulk_disable_request)
);
